// ===== rtl/fasta_sequence_parser_core_assert.svh =====
// Assertion macros shared by the parser RTL.
// FSP_ASSERT_IMP: same-cycle implication. FSP_ASSERT_NXT: next-cycle implication.
`ifndef FASTA_SEQUENCE_PARSER_CORE_ASSERT_SVH
`define FASTA_SEQUENCE_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FSP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FSP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/fsp_pkg.sv =====
package fsp_pkg;

    // fixed result field widths
    localparam int POS_W  = 32;
    localparam int IDX_W  = 16;
    localparam int BYTE_W = 8;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // config register indexes
    localparam logic CFG_REPLACE = 1'b0;
    localparam logic CFG_SEP     = 1'b1;

    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_GT = 8'h3e;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_A  = 8'h61;
    localparam logic [7:0] CH_C  = 8'h63;
    localparam logic [7:0] CH_G  = 8'h67;
    localparam logic [7:0] CH_T  = 8'h74;
    localparam logic [7:0] SEP_RESET = 8'hff;

    typedef enum logic [1:0] {
        KIND_SEQ  = 2'd0,
        KIND_DESC = 2'd1,
        KIND_NEW  = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_SEQ = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  symbol;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   desc_offset;
        logic [IDX_W-1:0]   seq_index;
        logic               has_separator;
        t_status            status;
        logic               last;
    } t_result;

    // write strobes from the parser into the result queue
    typedef struct packed {
        logic valid0;   // per-byte result
        logic valid1;   // end status, follows valid0 when both set
    } t_push;

    function automatic logic is_ws(input logic [7:0] b);
        logic r;
        r = (b == CH_SP) || (b inside {[8'd9:8'd13]});
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h41:8'h5a]}) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_acgt(input logic [7:0] b);
        logic r;
        r = (b == CH_A) || (b == CH_C) || (b == CH_G) || (b == CH_T);
        return r;
    endfunction

endpackage

// ===== rtl/fsp_parse.sv =====
module fsp_parse #(
    parameter int POS_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  logic [7:0]            i_replace_char,
    input  logic [7:0]            i_separator,
    output fsp_pkg::t_push        o_push,
    output fsp_pkg::t_result      o_res0,
    output fsp_pkg::t_result      o_res1
);

    `include "fasta_sequence_parser_core_assert.svh"

    logic                  r_in_header, n_in_header;
    logic                  r_copying,   n_copying;
    logic [COUNT_BITS-1:0] r_count,     n_count;
    logic [POS_BITS-1:0]   r_seq_len,   n_seq_len;
    logic [POS_BITS-1:0]   r_desc_len,  n_desc_len;
    logic [POS_BITS-1:0]   r_hdr_start, n_hdr_start;
    logic                  res0_valid;
    logic                  ws;
    logic [7:0]            low;

    function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
        logic [POS_BITS-1:0] r;
        r = (&v) ? v : v + {{(POS_BITS-1){1'b0}}, 1'b1};
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (&v) ? v : v + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        return r;
    endfunction

    function automatic logic [fsp_pkg::POS_W-1:0] pos_out(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+fsp_pkg::POS_W-1:0] e;
        e = {{fsp_pkg::POS_W{1'b0}}, v};
        return e[fsp_pkg::POS_W-1:0];
    endfunction

    function automatic logic [fsp_pkg::IDX_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+fsp_pkg::IDX_W-1:0] e;
        e = {{fsp_pkg::IDX_W{1'b0}}, v};
        return e[fsp_pkg::IDX_W-1:0];
    endfunction

    assign ws  = fsp_pkg::is_ws(i_byte);
    assign low = fsp_pkg::to_lower(i_byte);

    always_comb begin
        n_in_header = r_in_header;
        n_copying   = r_copying;
        n_count     = r_count;
        n_seq_len   = r_seq_len;
        n_desc_len  = r_desc_len;
        n_hdr_start = r_hdr_start;
        res0_valid  = 1'b0;
        o_res0      = '0;

        if (r_in_header) begin
            if (r_copying) begin
                res0_valid      = 1'b1;
                o_res0.kind     = fsp_pkg::KIND_DESC;
                o_res0.symbol   = ws ? fsp_pkg::CH_NL : i_byte;
                o_res0.position = pos_out(r_desc_len);
                n_desc_len      = sat_pos(r_desc_len);
                if (ws) begin
                    n_copying = 1'b0;
                end
            end
            if (i_byte == fsp_pkg::CH_NL) begin
                n_in_header = 1'b0;
            end
        end else if (i_byte == fsp_pkg::CH_GT) begin
            res0_valid      = 1'b1;
            o_res0.kind     = fsp_pkg::KIND_NEW;
            o_res0.position = pos_out(r_seq_len);
            n_hdr_start     = r_desc_len;
            n_count         = sat_cnt(r_count);
            // separator takes a sequence slot from the second record on
            if (r_count != '0) begin
                o_res0.symbol        = i_separator;
                o_res0.has_separator = 1'b1;
                n_seq_len            = sat_pos(r_seq_len);
            end
            n_in_header = 1'b1;
            n_copying   = 1'b1;
        end else if (!ws) begin
            res0_valid      = 1'b1;
            o_res0.kind     = fsp_pkg::KIND_SEQ;
            o_res0.symbol   = (i_replace_char != 8'h00 && !fsp_pkg::is_acgt(low)) ?
                              i_replace_char : low;
            o_res0.position = pos_out(r_seq_len);
            n_seq_len       = sat_pos(r_seq_len);
        end

        o_res0.desc_offset = pos_out(n_hdr_start);
        o_res0.seq_index   = cnt_out(n_count);
    end

    // end status sees the state left by the final byte
    always_comb begin
        o_res1             = '0;
        o_res1.kind        = fsp_pkg::KIND_END;
        o_res1.position    = pos_out(n_seq_len);
        o_res1.desc_offset = pos_out(n_desc_len);
        o_res1.seq_index   = cnt_out(n_count);
        o_res1.last        = 1'b1;
        if (n_count == '0) begin
            o_res1.status = fsp_pkg::ST_NO_SEQ;
        end else if (n_seq_len == '0) begin
            o_res1.status = fsp_pkg::ST_EMPTY;
        end else begin
            o_res1.status = fsp_pkg::ST_OK;
        end
    end

    assign o_push.valid0 = i_accept & res0_valid;
    assign o_push.valid1 = i_accept & i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
            r_copying   <= 1'b0;
            r_count     <= '0;
            r_seq_len   <= '0;
            r_desc_len  <= '0;
            r_hdr_start <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_in_header <= 1'b0;
                r_copying   <= 1'b0;
                r_count     <= '0;
                r_seq_len   <= '0;
                r_desc_len  <= '0;
                r_hdr_start <= '0;
            end else begin
                r_in_header <= n_in_header;
                r_copying   <= n_copying;
                r_count     <= n_count;
                r_seq_len   <= n_seq_len;
                r_desc_len  <= n_desc_len;
                r_hdr_start <= n_hdr_start;
            end
        end
    end

    `FSP_ASSERT_IMP(a_copy_in_hdr, i_clk, i_rst_n, r_copying, r_in_header)
    `FSP_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, i_accept && i_last,
        r_count == '0 && !r_in_header && r_seq_len == '0 && r_desc_len == '0)
    `FSP_ASSERT_IMP(a_new_counts, i_clk, i_rst_n,
        o_push.valid0 && o_res0.kind == fsp_pkg::KIND_NEW, n_count != '0)

endmodule

// ===== rtl/fsp_outq.sv =====
module fsp_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsp_pkg::t_push   i_push,
    input  fsp_pkg::t_result i_res0,
    input  fsp_pkg::t_result i_res1,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output fsp_pkg::t_result o_head
);

    `include "fasta_sequence_parser_core_assert.svh"

    fsp_pkg::t_result                r_q [fsp_pkg::QDEPTH];
    logic [fsp_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [fsp_pkg::QCNT_W-1:0]      r_count,  n_count;
    logic [fsp_pkg::QPTR_W-1:0]      wr_ptr1;
    logic [fsp_pkg::QCNT_W-1:0]      push_n;
    logic                            pop;

    // room for two entries is kept so any byte can be taken
    assign o_full  = r_count > fsp_pkg::QCNT_W'(fsp_pkg::QDEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_q[r_rd_ptr];
    assign pop     = o_valid & ~i_stall;
    assign push_n  = fsp_pkg::QCNT_W'(i_push.valid0) + fsp_pkg::QCNT_W'(i_push.valid1);
    assign wr_ptr1 = r_wr_ptr + fsp_pkg::QPTR_W'(i_push.valid0);
    assign n_count = r_count + push_n - fsp_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_q[r_wr_ptr] <= i_res0;
        end
        if (i_push.valid1) begin
            r_q[wr_ptr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[fsp_pkg::QPTR_W-1:0];
            r_rd_ptr <= r_rd_ptr + fsp_pkg::QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

    `FSP_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1,
        r_count <= fsp_pkg::QCNT_W'(fsp_pkg::QDEPTH))
    `FSP_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push.valid0 || i_push.valid1,
        r_count <= fsp_pkg::QCNT_W'(fsp_pkg::QDEPTH - 2))
    `FSP_ASSERT_NXT(a_pop_drains, i_clk, i_rst_n,
        !i_push.valid0 && !i_push.valid1 && pop,
        r_count == $past(r_count) - fsp_pkg::QCNT_W'(1))

endmodule

// ===== rtl/fasta_sequence_parser_core.sv =====
// Multi-FASTA stream parser. File bytes enter one per request on the input
// channel, with i_in_last on the final byte; parsed results leave one per
// request on the output channel. A '>' outside a header opens a new record
// (kind 2, with the separator from the second record on), the header word
// up to the first whitespace comes out as description bytes ending in a
// newline (kind 1), the rest of the header line is dropped, and every other
// non-whitespace byte is lowercased and optionally replaced (kind 0). After
// the final byte an end status (kind 3, o_last high) follows, and all parse
// state returns to reset so the next byte starts a new file. Throughput is
// one byte per clock while o_in_stall is low; each accepted byte is parsed
// and its results go into a 4-entry result queue. A byte makes at most one
// result except the final byte, which can make two: one extra result per file.
// o_in_stall rises when the queue holds more than two results: when the
// output side stalls, or when final bytes come so close together that their
// extra status results pile up faster than one result per clock drains them.
// Config writes (index 0 replace char, index 1 separator) are always ready
// and should be made while idle.
module fasta_sequence_parser_core #(
    parameter int POS_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_symbol,
    output logic [31:0] o_position,
    output logic [31:0] o_desc_offset,
    output logic [15:0] o_seq_index,
    output logic        o_has_separator,
    output logic [1:0]  o_status,
    output logic        o_last,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]       r_replace_char;
    logic [7:0]       r_separator;
    logic             in_accept;
    logic             q_full;
    fsp_pkg::t_push   push;
    fsp_pkg::t_result res0, res1, head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid & ~q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_char <= 8'h00;
            r_separator    <= fsp_pkg::SEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fsp_pkg::CFG_REPLACE: r_replace_char <= i_cfg_data;
                fsp_pkg::CFG_SEP:     r_separator    <= i_cfg_data;
                default:              r_separator    <= r_separator;
            endcase
        end
    end

    // combinational parse of the accepted byte
    fsp_parse #(
        .POS_BITS   (POS_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_byte         (i_in_byte),
        .i_last         (i_in_last),
        .i_replace_char (r_replace_char),
        .i_separator    (r_separator),
        .o_push         (push),
        .o_res0         (res0),
        .o_res1         (res1)
    );

    // result queue, decouples output stall from byte intake
    fsp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_head  (head)
    );

    assign o_kind          = head.kind;
    assign o_symbol        = head.symbol;
    assign o_position      = head.position;
    assign o_desc_offset   = head.desc_offset;
    assign o_seq_index     = head.seq_index;
    assign o_has_separator = head.has_separator;
    assign o_status        = head.status;
    assign o_last          = head.last;

endmodule

// ===== dv/tb_fasta_sequence_parser_core.sv =====
// Self-checking bench for the multi-FASTA byte parser.
// Bytes go in on the input channel; every result that comes out is
// compared field by field with an in-bench model of the parser.
module tb_fasta_sequence_parser_core;

    // clock, reset, DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_symbol;
    logic [31:0] o_position;
    logic [31:0] o_desc_offset;
    logic [15:0] o_seq_index;
    logic        o_has_separator;
    logic [1:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    fasta_sequence_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_symbol        (o_symbol),
        .o_position      (o_position),
        .o_desc_offset   (o_desc_offset),
        .o_seq_index     (o_seq_index),
        .o_has_separator (o_has_separator),
        .o_status        (o_status),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser model state, mirrors the DUT's registers
    logic [7:0]  cfg_replace = 8'h00;
    logic [7:0]  cfg_sep     = fsp_pkg::SEP_RESET;
    logic        hdr_active  = 1'b0;
    logic        hdr_copying = 1'b0;
    logic [15:0] rec_count   = '0;
    logic [31:0] seq_len     = '0;
    logic [31:0] desc_len    = '0;
    logic [31:0] hdr_start   = '0;

    // results the parser owes us, oldest first
    fsp_pkg::t_result predicted_results[$];

    int err_count = 0;

    // idling knobs: sender gap odds, receiver stall odds (percent)
    int   src_pct  = 0;
    int   sink_pct = 0;
    logic hold_on  = 1'b0;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    task automatic queue_result(input fsp_pkg::t_kind k, input logic [7:0] sym,
                                input logic [31:0] pos, input logic sep,
                                input fsp_pkg::t_status st, input logic fin);
        fsp_pkg::t_result r;
        r.kind          = k;
        r.symbol        = sym;
        r.position      = pos;
        r.desc_offset   = hdr_start;
        r.seq_index     = rec_count;
        r.has_separator = sep;
        r.status        = st;
        r.last          = fin;
        predicted_results.push_back(r);
    endtask

    // Advance the model by one file byte and queue what it should emit.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [7:0]       c;
        logic [31:0]      p;
        fsp_pkg::t_status st;
        if (hdr_active) begin
            if (hdr_copying) begin
                c = b;
                // header word ends at the first blank, written as a newline
                if (is_blank(b)) begin
                    hdr_copying = 1'b0;
                    c = fsp_pkg::CH_NL;
                end
                queue_result(fsp_pkg::KIND_DESC, c, desc_len, 1'b0, fsp_pkg::ST_OK, 1'b0);
                if (desc_len != '1) desc_len = desc_len + 32'd1;
            end
            if (b == fsp_pkg::CH_NL) hdr_active = 1'b0;
        end else if (b == fsp_pkg::CH_GT) begin
            hdr_start = desc_len;
            if (rec_count != 0) begin
                // separator takes one sequence slot
                p = seq_len;
                if (seq_len != '1) seq_len = seq_len + 32'd1;
                if (rec_count != '1) rec_count = rec_count + 16'd1;
                queue_result(fsp_pkg::KIND_NEW, cfg_sep, p, 1'b1, fsp_pkg::ST_OK, 1'b0);
            end else begin
                rec_count = rec_count + 16'd1;
                queue_result(fsp_pkg::KIND_NEW, 8'h00, seq_len, 1'b0, fsp_pkg::ST_OK, 1'b0);
            end
            hdr_active  = 1'b1;
            hdr_copying = 1'b1;
        end else if (!is_blank(b)) begin
            c = b;
            if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
            if (cfg_replace != 0 && c != fsp_pkg::CH_A && c != fsp_pkg::CH_C &&
                c != fsp_pkg::CH_G && c != fsp_pkg::CH_T)
                c = cfg_replace;
            queue_result(fsp_pkg::KIND_SEQ, c, seq_len, 1'b0, fsp_pkg::ST_OK, 1'b0);
            if (seq_len != '1) seq_len = seq_len + 32'd1;
        end

        if (fin) begin
            if (rec_count == 0) st = fsp_pkg::ST_NO_SEQ;
            else if (seq_len == 0) st = fsp_pkg::ST_EMPTY;
            else st = fsp_pkg::ST_OK;
            hdr_start = desc_len;
            queue_result(fsp_pkg::KIND_END, 8'h00, seq_len, 1'b0, st, 1'b1);
            // file done: parse state back to reset, registers kept
            hdr_active  = 1'b0;
            hdr_copying = 1'b0;
            rec_count   = '0;
            seq_len     = '0;
            desc_len    = '0;
            hdr_start   = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Result checker: every request taken on the output side is matched
    // against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        fsp_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_results.size() == 0) begin
                report_mismatch($sformatf("unpredicted result, kind %0d", o_kind));
            end else begin
                want = predicted_results.pop_front();
                cmp_field("kind", 32'(o_kind), 32'(want.kind));
                cmp_field("symbol", 32'(o_symbol), 32'(want.symbol));
                cmp_field("position", o_position, want.position);
                cmp_field("desc_offset", o_desc_offset, want.desc_offset);
                cmp_field("seq_index", 32'(o_seq_index), 32'(want.seq_index));
                cmp_field("has_separator", 32'(o_has_separator), 32'(want.has_separator));
                cmp_field("status", 32'(o_status), 32'(want.status));
                cmp_field("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // Receiver stall: random per cycle, or held high for a long hold-off.
    always @(posedge i_clk) begin
        if (hold_on) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (sink_pct > 0) && ($urandom_range(99) < sink_pct);
        end
    end

    task automatic set_idling(input int src, input int sink);
        src_pct  = src;
        sink_pct <= sink;
    endtask

    // Offer one byte; returns at the edge where the request is taken.
    // Valid is left high so a back-to-back request needs no toggle.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = 0;
        while (src_pct > 0 && $urandom_range(99) < src_pct && gap < 16) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= fin;
        parse_byte(b, fin);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
    endtask

    // Drop valid, wait for every owed result, then let the pipe settle
    // (a blank byte produces nothing but may still be in flight).
    task automatic drain();
        i_in_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Both registers in two back-to-back requests; only while idle.
    task automatic load_config(input logic [7:0] repl, input logic [7:0] sep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fsp_pkg::CFG_REPLACE;
        i_cfg_data  <= repl;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_replace = repl;
        i_cfg_index <= fsp_pkg::CFG_SEP;
        i_cfg_data  <= sep;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_sep = sep;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_blank();
        logic [7:0] pool[6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
        return pool[$urandom_range(5)];
    endfunction

    function automatic logic [7:0] rand_residue();
        string pool;
        pool = "acgtACGTnNRYxX*-";
        if ($urandom_range(7) == 0) return 8'($urandom_range(255));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // One random multi-FASTA file, mostly well formed, sometimes with
    // stray or garbage bytes spliced in. Last flag on its final byte.
    task automatic send_random_file(inout int sent);
        logic [7:0] fbytes[$];
        int nrec, nlines, r, ln, idx;
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 4)) fbytes.push_back(rand_residue());
        nrec = $urandom_range(0, 3);
        for (r = 0; r < nrec; r++) begin
            fbytes.push_back(fsp_pkg::CH_GT);
            repeat ($urandom_range(0, 6)) fbytes.push_back(8'($urandom_range(33, 126)));
            if ($urandom_range(1)) begin
                fbytes.push_back(rand_blank());
                repeat ($urandom_range(0, 5))
                    fbytes.push_back($urandom_range(1) ? 8'($urandom_range(33, 126)) :
                                                         fsp_pkg::CH_SP);
            end
            fbytes.push_back(fsp_pkg::CH_NL);
            nlines = $urandom_range(0, 3);
            for (ln = 0; ln < nlines; ln++) begin
                repeat ($urandom_range(0, 12)) fbytes.push_back(rand_residue());
                if ($urandom_range(3) == 0) fbytes.push_back(8'd13);
                fbytes.push_back(fsp_pkg::CH_NL);
            end
        end
        // broken files: raw bytes anywhere
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                idx = $urandom_range(fbytes.size());
                fbytes.insert(idx, 8'($urandom_range(255)));
            end
        end
        if (fbytes.size() == 0) fbytes.push_back(8'($urandom_range(255)));
        foreach (fbytes[i]) send_byte(fbytes[i], i == fbytes.size() - 1);
        sent += fbytes.size();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Symbols before any header, then a final 0xff: no-sequence status,
    // and two results on the final byte.
    task automatic test_before_first_record();
        send_byte("A", 1'b0);
        send_byte(fsp_pkg::CH_SP, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // Header copy and skip, '>' inside a header, every blank code,
    // lowercasing, separator, zero-length header word, final 0x00.
    task automatic test_record_structure();
        send_text(">I>", 1'b0);
        send_byte(8'd11, 1'b0);        // ends header word
        send_byte("x", 1'b0);          // skipped rest of line
        send_byte(8'd13, 1'b0);
        send_byte(fsp_pkg::CH_NL, 1'b0);
        send_text("aC", 1'b0);
        send_byte(8'd9, 1'b0);
        send_byte(8'd12, 1'b0);
        send_text("Tz", 1'b0);
        send_byte(fsp_pkg::CH_GT, 1'b0);   // second record, with separator
        send_byte(fsp_pkg::CH_SP, 1'b0);   // empty header word
        send_byte(fsp_pkg::CH_NL, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Record with no sequence, last byte on a header newline; then a file
    // that is a lone '>'.
    task automatic test_empty_record();
        send_text(">h\n", 1'b1);
        send_byte(fsp_pkg::CH_GT, 1'b1);
    endtask

    task automatic test_random_files(input int src, input int sink, input logic [7:0] repl,
                                     input logic [7:0] sep, input int n_items);
        int sent;
        sent = 0;
        drain();
        load_config(repl, sep);
        set_idling(src, sink);
        while (sent < n_items) send_random_file(sent);
    endtask

    // Receiver holds off for a long stretch while bytes keep coming,
    // so the result queue fills and the input side stalls.
    task automatic test_input_backpressure();
        int sent;
        sent = 0;
        drain();
        load_config(fsp_pkg::CH_C, 8'h5a);
        set_idling(0, 0);
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_on <= 1'b0;
            end
            begin
                while (sent < 80) send_random_file(sent);
                i_in_valid <= 1'b0;
            end
        join
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= 8'h00;
        i_in_last   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= fsp_pkg::CFG_REPLACE;
        i_cfg_data  <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        test_before_first_record();
        test_record_structure();
        test_empty_record();

        // random files across idling styles and register settings
        test_random_files(0, 0, 8'h00, 8'hff, 400);
        test_random_files(45, 0, 8'hff, 8'h00, 400);
        test_random_files(0, 45, "n", 8'($urandom_range(255)), 400);
        test_random_files(20, 20, 8'($urandom_range(1, 255)), 8'($urandom_range(255)), 400);

        test_input_backpressure();

        drain();
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== fasta_sequence_parser_core.f =====
+incdir+rtl
rtl/fsp_pkg.sv
rtl/fsp_parse.sv
rtl/fsp_outq.sv
rtl/fasta_sequence_parser_core.sv
dv/tb_fasta_sequence_parser_core.sv
